### rtl/core/three_level_priority_queue_defines.svh
// Assertion macros for the priority queue RTL.
`ifndef THREE_LEVEL_PRIORITY_QUEUE_DEFINES_SVH
`define THREE_LEVEL_PRIORITY_QUEUE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define TLPQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define TLPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/tlpq_pkg.sv
// Types and constants for the three-level priority queue.
`timescale 1ns / 1ps
package tlpq_pkg;

  localparam logic [1:0] OP_PUT   = 2'd0;
  localparam logic [1:0] OP_GET   = 2'd1;
  localparam logic [1:0] OP_ACCEL = 2'd2;

  localparam logic [1:0] LVL_LOW    = 2'd0;
  localparam logic [1:0] LVL_NORMAL = 2'd1;
  localparam logic [1:0] LVL_HIGH   = 2'd2;

  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_GET_EMPTY = 2'd1;
  localparam logic [1:0] ST_PUT_FULL  = 2'd2;

  localparam int TAG_BITS   = 16;
  localparam int COUNT_BITS = 7;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  typedef struct packed {
    logic load;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic out_blocked;
  } stat_t;

endpackage

### rtl/core/tlpq_ctrl.sv
// Controller state machine for the priority queue.
`timescale 1ns / 1ps
module tlpq_ctrl
  import tlpq_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_stall,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    unique case (state)
      S_IDLE: begin
        // No request is taken while reset is held.
        in_stall = rst;
        if (in_valid && !rst) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        // Commit only once the result register can take the answer.
        if (!stat.out_blocked) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

### rtl/core/tlpq_datapath.sv
// Linked-list memories, level registers and result register of the queue.
`timescale 1ns / 1ps
module tlpq_datapath
  import tlpq_pkg::*;
#(
  parameter int DEPTH     = 64,
  parameter int TAG_WIDTH = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cmd_t                  cmd,
  output stat_t                 stat,
  input  logic [1:0]            operation,
  input  logic [1:0]            level,
  input  logic [TAG_BITS-1:0]   tag,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            status,
  output logic [TAG_BITS-1:0]   out_tag,
  output logic [1:0]            out_level,
  output logic [COUNT_BITS-1:0] total_count
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [AW-1:0] LAST_C  = AW'(DEPTH - 1);

  // Slot memories, undefined until written.
  logic [TAG_WIDTH-1:0] tag_store [DEPTH];
  logic [AW-1:0]        next_link [DEPTH];
  logic [AW-1:0]        free_fifo [DEPTH];

  logic [AW-1:0] level_head  [3];
  logic [AW-1:0] level_tail  [3];
  logic [CW-1:0] level_count [3];

  // Slots never used yet are handed out by a counter; freed slots recycle.
  logic [CW-1:0] fresh;
  logic [AW-1:0] free_rd_ptr, free_wr_ptr;
  logic [CW-1:0] total;

  // Latched request and registered memory reads.
  logic [1:0]           op_q, lvl_q, sel_q;
  logic                 empty_q, full_q;
  logic [TAG_WIDTH-1:0] tag_q, tag_rd;
  logic [AW-1:0]        next_rd, free_rd, slot_q;

  logic [1:0]    sel;
  logic          empty;
  logic [AW-1:0] alloc;
  logic          out_take;

  assign total = level_count[0] + level_count[1] + level_count[2];

  always_comb begin
    empty = 1'b0;
    sel   = LVL_LOW;
    priority if (level_count[2] != '0) begin
      sel = LVL_HIGH;
    end else if (level_count[1] != '0) begin
      sel = LVL_NORMAL;
    end else if (level_count[0] != '0) begin
      sel = LVL_LOW;
    end else begin
      empty = 1'b1;
    end
  end

  assign alloc    = (fresh != DEPTH_C) ? fresh[AW-1:0] : free_rd;
  assign out_take = out_valid && !out_stall;
  assign stat.out_blocked = out_valid && out_stall;

  // Request capture and memory reads.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q    <= operation;
      lvl_q   <= (level > LVL_HIGH) ? LVL_HIGH : level;
      tag_q   <= TAG_WIDTH'(tag);
      sel_q   <= sel;
      empty_q <= empty;
      full_q  <= (total == DEPTH_C);
      slot_q  <= level_head[sel];
      tag_rd  <= tag_store[level_head[sel]];
      next_rd <= next_link[level_head[sel]];
      free_rd <= free_fifo[free_rd_ptr];
    end
  end

  // Memory writes at commit.
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      unique case (op_q)
        OP_PUT: begin
          if (!full_q) begin
            tag_store[alloc] <= tag_q;
            if (level_count[lvl_q] != '0) begin
              next_link[level_tail[lvl_q]] <= alloc;
            end
          end
        end
        OP_GET: begin
          if (!empty_q) begin
            free_fifo[free_wr_ptr] <= slot_q;
          end
        end
        OP_ACCEL: begin
          if (level_count[0] != '0 && level_count[2] != '0) begin
            next_link[level_tail[2]] <= level_head[0];
          end
        end
        default: ;
      endcase
    end
  end

  // List control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      fresh       <= '0;
      free_rd_ptr <= '0;
      free_wr_ptr <= '0;
      for (int i = 0; i < 3; i++) begin
        level_head[i]  <= '0;
        level_tail[i]  <= '0;
        level_count[i] <= '0;
      end
    end else if (cmd.commit) begin
      unique case (op_q)
        OP_PUT: begin
          if (!full_q) begin
            if (fresh != DEPTH_C) begin
              fresh <= fresh + 1'b1;
            end else begin
              free_rd_ptr <= (free_rd_ptr == LAST_C) ? '0 : free_rd_ptr + 1'b1;
            end
            if (level_count[lvl_q] == '0) begin
              level_head[lvl_q] <= alloc;
            end
            level_tail[lvl_q]  <= alloc;
            level_count[lvl_q] <= level_count[lvl_q] + 1'b1;
          end
        end
        OP_GET: begin
          if (!empty_q) begin
            level_head[sel_q]  <= next_rd;
            level_count[sel_q] <= level_count[sel_q] - 1'b1;
            free_wr_ptr <= (free_wr_ptr == LAST_C) ? '0 : free_wr_ptr + 1'b1;
          end
        end
        OP_ACCEL: begin
          if (level_count[0] != '0) begin
            if (level_count[2] == '0) begin
              level_head[2] <= level_head[0];
            end
            level_tail[2]  <= level_tail[0];
            level_count[2] <= level_count[2] + level_count[0];
            level_count[0] <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      status    <= ST_DONE;
      out_tag   <= '0;
      out_level <= LVL_LOW;
      unique case (op_q)
        OP_PUT: begin
          if (full_q) begin
            status      <= ST_PUT_FULL;
            total_count <= COUNT_BITS'(total);
          end else begin
            total_count <= COUNT_BITS'(total + 1'b1);
          end
        end
        OP_GET: begin
          if (empty_q) begin
            status      <= ST_GET_EMPTY;
            total_count <= COUNT_BITS'(total);
          end else begin
            out_tag     <= TAG_BITS'(tag_rd);
            out_level   <= sel_q;
            total_count <= COUNT_BITS'(total - 1'b1);
          end
        end
        default: total_count <= COUNT_BITS'(total);
      endcase
    end
  end

endmodule

### rtl/core/three_level_priority_queue.sv
// Top level of the three-level priority queue.
//
//   channel   direction   handshake             payload
//   request   in          in_valid / in_stall   operation, level, tag
//   result    out         out_valid / out_stall status, out_tag, out_level, total_count
//
// Each request is accepted in S_IDLE, which reads the slot memories at the
// head of the chosen level, and committed in S_EXEC, which writes the list
// update; next_link is read at accept and written back at commit.
// A waiting result stalls the commit cycle until it is taken; a new request
// can be accepted while the previous result still waits.
// Reset is synchronous and leaves all levels empty; no clearing pass is needed.
`timescale 1ns / 1ps
`include "three_level_priority_queue_defines.svh"
module three_level_priority_queue
  import tlpq_pkg::*;
#(
  parameter int DEPTH     = 64,
  parameter int TAG_WIDTH = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            operation,
  input  logic [1:0]            level,
  input  logic [TAG_BITS-1:0]   tag,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            status,
  output logic [TAG_BITS-1:0]   out_tag,
  output logic [1:0]            out_level,
  output logic [COUNT_BITS-1:0] total_count
);

  cmd_t  cmd;
  stat_t stat;

  // The controller sequences accept and commit; the datapath holds the lists.
  tlpq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  tlpq_datapath #(
    .DEPTH     (DEPTH),
    .TAG_WIDTH (TAG_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .operation   (operation),
    .level       (level),
    .tag         (tag),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .out_tag     (out_tag),
    .out_level   (out_level),
    .total_count (total_count)
  );

  // An accepted request always holds off the next one for its commit cycle.
  `TLPQ_ASSERT_NEXT(a_accept_busy, in_valid && !in_stall, in_stall, "request accepted while busy")
  // A commit never happens while a result is blocked.
  `TLPQ_ASSERT_NOW(a_no_overwrite, cmd.commit, !stat.out_blocked, "result overwritten")
  // Failed requests return no tag.
  `TLPQ_ASSERT_NOW(a_fail_zero, out_valid && status != ST_DONE, out_tag == '0 && out_level == '0, "failed request carries data")

endmodule

### tb/tlpq_checker.sv
// Predictor and scoreboard that watch both channels of the priority queue.
`timescale 1ns / 1ps
module tlpq_checker
  import tlpq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic [1:0]            operation,
  input  logic [1:0]            level,
  input  logic [TAG_BITS-1:0]   tag,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic [1:0]            status,
  input  logic [TAG_BITS-1:0]   out_tag,
  input  logic [1:0]            out_level,
  input  logic [COUNT_BITS-1:0] total_count,
  output int                    fail_count,
  output int                    pending,
  output int                    results_seen
);

  localparam int SLOTS     = 64;
  localparam int DUE_SLOTS = 8;

  typedef struct packed {
    logic [1:0]            st;
    logic [TAG_BITS-1:0]   tg;
    logic [1:0]            lv;
    logic [COUNT_BITS-1:0] cnt;
  } answer_t;

  // Expected answers in request order, kept in a small ring.
  answer_t answers_due [DUE_SLOTS];
  int      due_wr;
  int      due_rd;

  logic [TAG_BITS-1:0] slot_tag [SLOTS];
  logic [5:0]          slot_next[SLOTS];
  logic [5:0]          head[3];
  logic [5:0]          tail[3];
  int                  depth_of[3];
  logic [SLOTS-1:0]    vacant;

  assign pending = due_wr - due_rd;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d expected %0d", what, got, want);
    fail_count++;
  endtask

  function automatic answer_t queue_step(input logic [1:0] op, input logic [1:0] lvl_in,
                                         input logic [TAG_BITS-1:0] t);
    answer_t a;
    int lv;
    int s;
    a = '0;
    if (op == OP_PUT) begin
      lv = (lvl_in > LVL_HIGH) ? LVL_HIGH : lvl_in;
      if (depth_of[0] + depth_of[1] + depth_of[2] >= SLOTS) begin
        a.st = ST_PUT_FULL;
      end else begin
        s = 0;
        while (!vacant[s]) s++;
        vacant[s] = 1'b0;
        slot_tag[s] = t;
        slot_next[s] = '0;
        if (depth_of[lv] == 0) head[lv] = 6'(s);
        else slot_next[tail[lv]] = 6'(s);
        tail[lv] = 6'(s);
        depth_of[lv]++;
      end
    end else if (op == OP_GET) begin
      lv = 2;
      while (lv >= 0 && depth_of[lv] == 0) lv--;
      if (lv < 0) begin
        a.st = ST_GET_EMPTY;
      end else begin
        s = head[lv];
        a.tg = slot_tag[s];
        a.lv = 2'(lv);
        depth_of[lv]--;
        if (depth_of[lv] == 0) begin
          head[lv] = '0;
          tail[lv] = '0;
        end else begin
          head[lv] = slot_next[s];
        end
        vacant[s] = 1'b1;
      end
    end else if (op == OP_ACCEL && depth_of[0] != 0) begin
      // The whole low list is spliced behind the high list.
      if (depth_of[2] == 0) head[2] = head[0];
      else slot_next[tail[2]] = head[0];
      tail[2] = tail[0];
      depth_of[2] += depth_of[0];
      depth_of[0] = 0;
      head[0] = '0;
      tail[0] = '0;
    end
    a.cnt = COUNT_BITS'(depth_of[0] + depth_of[1] + depth_of[2]);
    return a;
  endfunction

  initial begin
    fail_count = 0;
    results_seen = 0;
    due_wr = 0;
    due_rd = 0;
    vacant = '1;
    for (int i = 0; i < 3; i++) begin
      head[i] = '0;
      tail[i] = '0;
      depth_of[i] = 0;
    end
  end

  always @(posedge clk) begin
    answer_t want;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        answers_due[due_wr[2:0]] = queue_step(operation, level, tag);
        due_wr++;
      end
      if (out_valid && !out_stall) begin
        results_seen++;
        if (due_wr == due_rd) begin
          report_mismatch("unexpected result, status", status, 0);
        end else begin
          want = answers_due[due_rd[2:0]];
          due_rd++;
          if (status != want.st) report_mismatch("status", status, want.st);
          if (out_tag != want.tg) report_mismatch("out_tag", out_tag, want.tg);
          if (out_level != want.lv) report_mismatch("out_level", out_level, want.lv);
          if (total_count != want.cnt) report_mismatch("total_count", total_count, want.cnt);
        end
      end
    end
  end

endmodule

### tb/tb_three_level_priority_queue.sv
// Stimulus and verdict for the three-level priority queue.
`timescale 1ns / 1ps
module tb_three_level_priority_queue;
  import tlpq_pkg::*;

  // Codes outside the legal range, used to probe the saturation and no-op cases.
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [1:0] LVL_OVER  = 2'd3;

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_stall;
  logic [1:0]            operation;
  logic [1:0]            level;
  logic [TAG_BITS-1:0]   tag;
  logic                  out_valid;
  logic                  out_stall;
  logic [1:0]            status;
  logic [TAG_BITS-1:0]   out_tag;
  logic [1:0]            out_level;
  logic [COUNT_BITS-1:0] total_count;

  int fail_count;
  int pending;
  int results_seen;
  int cycle_count;
  int requests_sent;
  // Percent chance per cycle that the sender idles or the receiver stalls.
  int send_idle_pct;
  int recv_stall_pct;

  three_level_priority_queue u_top (.*);

  tlpq_checker u_checker (.*);

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // The run is bounded far beyond the slowest correct run, even under the
  // heaviest stalling.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > 400000) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // The receiver stalls at random, decided at each falling edge.
  always @(negedge clk) begin
    if (rst) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Presents one request and holds it until it is accepted. Idle cycles are
  // inserted before it according to the current sender idling rate. Valid
  // stays up after acceptance until the next call or a drain decides.
  task automatic send_request(input logic [1:0] op, input logic [1:0] lvl,
                              input logic [TAG_BITS-1:0] t);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid  <= 1'b0;
      operation <= 2'($urandom_range(3));
      level     <= 2'($urandom_range(3));
      tag       <= TAG_BITS'($urandom);
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    operation <= op;
    level     <= lvl;
    tag       <= t;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    requests_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  // A phase of random requests. fill_bias sets the percent share of puts;
  // accelerates and unused codes take ten percent and gets take the rest.
  task automatic random_phase(input int n, input int fill_bias);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 3) begin
        send_request(OP_UNUSED, 2'($urandom_range(3)), TAG_BITS'($urandom));
      end else if (r < 10) begin
        send_request(OP_ACCEL, 2'($urandom_range(3)), TAG_BITS'($urandom));
      end else if (r < 10 + fill_bias) begin
        send_request(OP_PUT, 2'($urandom_range(3)), TAG_BITS'($urandom));
      end else begin
        send_request(OP_GET, 2'($urandom_range(3)), TAG_BITS'($urandom));
      end
    end
  endtask

  initial begin
    cycle_count = 0;
    requests_sent = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rst = 1'b1;
    in_valid = 1'b0;
    out_stall = 1'b0;
    operation = OP_PUT;
    level = LVL_LOW;
    tag = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: get on empty, every level, tag extremes, the out-of-range
    // level and operation, accelerate both with and without low entries.
    send_request(OP_GET, LVL_LOW, 16'h0000);
    send_request(OP_ACCEL, LVL_LOW, 16'h0000);
    send_request(OP_PUT, LVL_LOW, 16'h0000);
    send_request(OP_PUT, LVL_LOW, 16'hFFFF);
    send_request(OP_PUT, LVL_NORMAL, 16'hA5A5);
    send_request(OP_PUT, LVL_HIGH, 16'h5A5A);
    send_request(OP_PUT, LVL_OVER, 16'h1234);
    send_request(OP_UNUSED, LVL_OVER, 16'hFFFF);
    send_request(OP_ACCEL, LVL_LOW, 16'h0000);
    send_request(OP_ACCEL, LVL_LOW, 16'h0000);
    for (int i = 0; i < 6; i++) send_request(OP_GET, LVL_LOW, 16'h0000);
    // Fill past capacity so a put is refused, then empty the queue again.
    for (int i = 0; i < 66; i++) begin
      send_request(OP_PUT, 2'($urandom_range(2)), TAG_BITS'($urandom));
    end
    send_request(OP_ACCEL, LVL_LOW, 16'h0000);
    for (int i = 0; i < 65; i++) send_request(OP_GET, LVL_LOW, 16'h0000);

    // The sender holds off here until every result has come back.
    drain_results();

    random_phase(325, 55);
    send_idle_pct = 61;
    random_phase(325, 35);
    send_idle_pct = 0;
    recv_stall_pct = 61;
    random_phase(325, 60);
    send_idle_pct = 26;
    recv_stall_pct = 26;
    random_phase(325, 45);

    drain_results();
    repeat (20) @(negedge clk);
    $display("Sent %0d requests and checked %0d results across four idling phases,",
             requests_sent, results_seen);
    $display("including full and empty queues and accelerate splices.");
    if (fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
